// File: design/wedge15_shape_and_gradient_defines.svh
// Assertion macros shared by the design files.
`ifndef WEDGE15_SHAPE_AND_GRADIENT_DEFINES_SVH
`define WEDGE15_SHAPE_AND_GRADIENT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define W15_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define W15_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

// File: design/w15_pkg.sv
package w15_pkg;
    localparam int FracBits = 14;
    localparam int InW = 16;
    localparam int OutW = 18;
    localparam int NodeCnt = 15;
    localparam int IdxW = 4;
    // Internal working width for products and sums.
    localparam int WW = 40;
    // Multiplier operand width; every operand stays well inside it.
    localparam int MulW = 32;
    localparam int WideW = 2 * MulW;

    typedef logic signed [InW-1:0] t_in;
    typedef logic signed [OutW-1:0] t_out;
    typedef logic signed [WW-1:0] t_w;

    localparam t_w One = t_w'(1) <<< FracBits;
    localparam t_out OutMax = t_out'((1 <<< (OutW - 1)) - 1);
    localparam t_out OutMin = t_out'(-(1 <<< (OutW - 1)));

    // Product rescaled by FracBits, rounded half toward +infinity.
    function automatic t_w qmul(input t_w a, input t_w b);
        logic signed [MulW-1:0] ma, mb;
        logic signed [WideW-1:0] p;
        ma = a[MulW-1:0];
        mb = b[MulW-1:0];
        p = WideW'(ma) * WideW'(mb) + (WideW'(1) <<< (FracBits - 1));
        return t_w'(p >>> FracBits);
    endfunction

    // Halving, rounded half toward +infinity.
    function automatic t_w qhalf(input t_w v);
        return (v + t_w'(1)) >>> 1;
    endfunction

    // Saturation to the output range.
    function automatic t_out sat(input t_w v);
        if (v > t_w'(OutMax)) return OutMax;
        if (v < t_w'(OutMin)) return OutMin;
        return t_out'(v);
    endfunction
endpackage

// File: design/w15_node_core.sv
// Pipelined evaluation of all fifteen node results for one point.
module w15_node_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  w15_pkg::t_in                i_xi,
    input  w15_pkg::t_in                i_eta,
    input  w15_pkg::t_in                i_zeta,
    output logic                        o_valid,
    output w15_pkg::t_out               o_res [w15_pkg::NodeCnt][4]
);
    import w15_pkg::*;

    // Stage 1 registers: basic linear terms.
    logic r_v1, r_v2, r_v3;
    t_w r_x, r_y, r_z, r_l, r_zm, r_zp;
    // Stage 2 registers: first products.
    t_w r_w, r_a, r_b, r_c, r_lz, r_xz, r_yz, r_lx, r_xy, r_yl;
    t_w r2_x, r2_y, r2_l, r2_zm, r2_zp;
    t_w v [NodeCnt][4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Stage 1: sign extension and linear combinations.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x  <= t_w'(i_xi);
            r_y  <= t_w'(i_eta);
            r_z  <= t_w'(i_zeta);
            r_l  <= One - t_w'(i_xi) - t_w'(i_eta);
            r_zm <= One - t_w'(i_zeta);
            r_zp <= One + t_w'(i_zeta);
        end
    end

    // Stage 2: one product per term.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w  <= One - qmul(r_z, r_z);
            r_a  <= qmul(r_l, (r_l <<< 1) - One);
            r_b  <= qmul(r_x, (r_x <<< 1) - One);
            r_c  <= qmul(r_y, (r_y <<< 1) - One);
            r_lz <= qmul(r_l, r_z);
            r_xz <= qmul(r_x, r_z);
            r_yz <= qmul(r_y, r_z);
            r_lx <= qmul(r_l, r_x);
            r_xy <= qmul(r_x, r_y);
            r_yl <= qmul(r_y, r_l);
            r2_x <= r_x;
            r2_y <= r_y;
            r2_l <= r_l;
            r2_zm <= r_zm;
            r2_zp <= r_zp;
        end
    end

    // Stage 3: second products, combination and saturation.
    always_comb begin
        t_w lw, xw, yw, g4l, g4x, g4y;
        lw  = qmul(r2_l, r_w);
        xw  = qmul(r2_x, r_w);
        yw  = qmul(r2_y, r_w);
        g4l = (r2_l <<< 2) - One;
        g4x = (r2_x <<< 2) - One;
        g4y = (r2_y <<< 2) - One;
        v[0][0] = qhalf(qmul(r_a, r2_zm) - lw);
        v[0][1] = qhalf(r_w - qmul(r2_zm, g4l));
        v[0][2] = v[0][1];
        v[0][3] = qhalf((r_lz <<< 1) - r_a);
        v[1][0] = qhalf(qmul(r_b, r2_zm) - xw);
        v[1][1] = qhalf(qmul(g4x, r2_zm) - r_w);
        v[1][2] = '0;
        v[1][3] = qhalf((r_xz <<< 1) - r_b);
        v[2][0] = qhalf(qmul(r_c, r2_zm) - yw);
        v[2][1] = '0;
        v[2][2] = qhalf(qmul(g4y, r2_zm) - r_w);
        v[2][3] = qhalf((r_yz <<< 1) - r_c);
        v[3][0] = qhalf(qmul(r_a, r2_zp) - lw);
        v[3][1] = qhalf(r_w - qmul(r2_zp, g4l));
        v[3][2] = v[3][1];
        v[3][3] = qhalf(r_a + (r_lz <<< 1));
        v[4][0] = qhalf(qmul(r_b, r2_zp) - xw);
        v[4][1] = qhalf(qmul(g4x, r2_zp) - r_w);
        v[4][2] = '0;
        v[4][3] = qhalf(r_b + (r_xz <<< 1));
        v[5][0] = qhalf(qmul(r_c, r2_zp) - yw);
        v[5][1] = '0;
        v[5][2] = qhalf(qmul(g4y, r2_zp) - r_w);
        v[5][3] = qhalf(r_c + (r_yz <<< 1));
        v[6][0] = qmul(r_lx, r2_zm) <<< 1;
        v[6][1] = qmul(r2_zm, r2_l - r2_x) <<< 1;
        v[6][2] = -(qmul(r2_x, r2_zm) <<< 1);
        v[6][3] = -(r_lx <<< 1);
        v[7][0] = qmul(r_xy, r2_zm) <<< 1;
        v[7][1] = qmul(r2_y, r2_zm) <<< 1;
        v[7][2] = qmul(r2_x, r2_zm) <<< 1;
        v[7][3] = -(r_xy <<< 1);
        v[8][0] = qmul(r_yl, r2_zm) <<< 1;
        v[8][1] = -(qmul(r2_y, r2_zm) <<< 1);
        v[8][2] = qmul(r2_zm, r2_l - r2_y) <<< 1;
        v[8][3] = -(r_yl <<< 1);
        v[9][0] = qmul(r_lx, r2_zp) <<< 1;
        v[9][1] = qmul(r2_zp, r2_l - r2_x) <<< 1;
        v[9][2] = -(qmul(r2_x, r2_zp) <<< 1);
        v[9][3] = r_lx <<< 1;
        v[10][0] = qmul(r_xy, r2_zp) <<< 1;
        v[10][1] = qmul(r2_y, r2_zp) <<< 1;
        v[10][2] = qmul(r2_x, r2_zp) <<< 1;
        v[10][3] = r_xy <<< 1;
        v[11][0] = qmul(r_yl, r2_zp) <<< 1;
        v[11][1] = -(qmul(r2_y, r2_zp) <<< 1);
        v[11][2] = qmul(r2_zp, r2_l - r2_y) <<< 1;
        v[11][3] = r_yl <<< 1;
        v[12][0] = lw;
        v[12][1] = -r_w;
        v[12][2] = -r_w;
        v[12][3] = -(r_lz <<< 1);
        v[13][0] = xw;
        v[13][1] = r_w;
        v[13][2] = '0;
        v[13][3] = -(r_xz <<< 1);
        v[14][0] = yw;
        v[14][1] = '0;
        v[14][2] = r_w;
        v[14][3] = -(r_yz <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NodeCnt; k++) begin
                for (int f = 0; f < 4; f++) begin
                    o_res[k][f] <= sat(v[k][f]);
                end
            end
        end
    end

    assign o_valid = r_v3;
endmodule

// File: design/wedge15_shape_and_gradient.sv
// Quadratic 15-node wedge shape functions and local derivatives.
// Input channel: one point (xi, eta, zeta) per beat, signed Q2.14, with
// i_valid / o_ready. Output channel: fifteen beats per point, node 0 to 14,
// each with node index, shape value and three derivatives in signed Q4.14,
// saturated, and o_last_node high on node 14.
// The first node beat leaves the output bank once the point has passed the
// arithmetic pipeline and been loaded; the remaining nodes follow one per cycle while i_ready is high.
// The point rate is set by the single result port that walks over the
// fifteen nodes held in the output bank. The three-stage arithmetic
// pipeline moves whenever its last stage holds no result or the bank loads, so
// a new point is taken while the previous one is still being sent.
// A stall on i_ready holds the current node beat; the pipeline fills behind
// it and then holds input ready low. Reset empties all stages and the bank.
module wedge15_shape_and_gradient (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  w15_pkg::t_in                    i_xi,
    input  w15_pkg::t_in                    i_eta,
    input  w15_pkg::t_in                    i_zeta,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [w15_pkg::IdxW-1:0]        o_node_index,
    output w15_pkg::t_out                   o_shape_value,
    output w15_pkg::t_out                   o_grad_xi,
    output w15_pkg::t_out                   o_grad_eta,
    output w15_pkg::t_out                   o_grad_zeta,
    output logic                            o_last_node
);
    import w15_pkg::*;
    `include "wedge15_shape_and_gradient_defines.svh"

    logic en, core_valid, load;
    t_out core_res [NodeCnt][4];
    t_out r_bank [NodeCnt][4];
    logic r_busy;
    logic [IdxW-1:0] r_idx;
    logic last;

    assign last = (r_idx == IdxW'(NodeCnt - 1));
    // The bank frees when its last beat leaves.
    assign load = !r_busy || (i_ready && last);
    assign en = !core_valid || load;
    assign o_ready = en;

    w15_node_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_xi    (i_xi),
        .i_eta   (i_eta),
        .i_zeta  (i_zeta),
        .o_valid (core_valid),
        .o_res   (core_res)
    );

    // Output bank and node counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx <= '0;
        end else if (load) begin
            r_busy <= core_valid;
            r_idx <= '0;
        end else if (i_ready) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && core_valid) begin
            r_bank <= core_res;
        end
    end

    assign o_valid = r_busy;
    assign o_node_index = r_idx;
    assign o_shape_value = r_bank[r_idx][0];
    assign o_grad_xi = r_bank[r_idx][1];
    assign o_grad_eta = r_bank[r_idx][2];
    assign o_grad_zeta = r_bank[r_idx][3];
    assign o_last_node = last;

    `W15_ASSERT_IMP(a_idx_range, i_clk, i_rst_n, r_busy, r_idx <= IdxW'(NodeCnt - 1))
    `W15_ASSERT_NEXT(a_hold, i_clk, i_rst_n, r_busy && !i_ready, r_busy && $stable(r_idx))
    `W15_ASSERT_IMP(a_ready, i_clk, i_rst_n, core_valid && r_busy && !i_ready, !o_ready)
endmodule
